@@ hdl/sws_pkg.sv @@
// Package for the symmetric weighted smoother: beat structs, register indexes
// and command/status structs shared by controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sws_pkg;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               sequence_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] smoothed_value;
    logic               final_output;
  } out_beat_t;

  localparam logic [1:0] REG_TAP_COUNT = 2'd0;
  localparam logic [1:0] REG_WEIGHTS_A = 2'd1;
  localparam logic [1:0] REG_WEIGHTS_B = 2'd2;

  typedef struct packed {
    logic shift_in;
    logic clear_acc;
    logic mac_en;
    logic div_start;
    logic drop;
    logic clear_cnt;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic mac_done;
    logic div_done;
    logic more;
    logic seq_last;
    logic emt_over;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ hdl/sws_datapath.sv @@
// Datapath of the smoother: sample window, counters, shared multiply-accumulate
// and a restoring divider. Depends on sws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sws_datapath import sws_pkg::*; #(
  parameter int MAX_TAPS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire in_beat_t    in_beat,
  input  wire logic [3:0]  tap_count,
  input  wire logic [63:0] weights_a,
  input  wire logic [63:0] weights_b,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  output out_beat_t        result
);
  localparam int DEPTH = 2 * MAX_TAPS;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 2);
  localparam int JW = $clog2(2 * MAX_TAPS + 1);
  localparam int AW = 40;
  localparam int WW = 21;

  logic [15:0]   win [DEPTH];
  logic [CW-1:0] rcv, emt;
  logic          last;
  logic [JW-1:0] step;
  logic signed [AW-1:0] acc;
  logic [WW-1:0] wsum;
  logic [AW:0]   rem;
  logic [AW:0]   quo;
  logic [6:0]    dcnt;
  logic          dbusy;
  logic signed [15:0] centre;

  logic [CW-1:0] k;
  always_comb begin
    if (tap_count == 4'd0) k = CW'(1);
    else if (32'(tap_count) > MAX_TAPS) k = CW'(MAX_TAPS);
    else k = CW'(tap_count);
  end

  function automatic logic [15:0] wt(input logic [JW-1:0] j,
                                     input logic [63:0] a, input logic [63:0] b);
    logic [15:0] r;
    r = '0;
    case (j)
      JW'(0): r = a[15:0];
      JW'(1): r = a[31:16];
      JW'(2): r = a[47:32];
      JW'(3): r = a[63:48];
      JW'(4): r = b[15:0];
      JW'(5): r = b[31:16];
      JW'(6): r = b[47:32];
      JW'(7): r = b[63:48];
      default: r = '0;
    endcase
    return r;
  endfunction

  // step s<k: right side (p+s); step k..2k-2: left side distance s-k+1
  logic [JW-1:0] tap_dist;
  logic          right_side, present;
  logic signed [CW+1:0] pos;
  logic [CW-1:0] widx;
  logic [15:0]   w;
  logic signed [15:0] smp;
  always_comb begin
    right_side = ({1'b0, step} < (JW+1)'(k));
    tap_dist = right_side ? step : JW'(step - JW'(k) + JW'(1));
    if (right_side) pos = $signed({2'b0, emt}) + $signed({1'b0, (CW+1)'(tap_dist)});
    else pos = $signed({2'b0, emt}) - $signed({1'b0, (CW+1)'(tap_dist)});
    present = right_side ? (pos < $signed({2'b0, rcv})) : (pos >= 0);
    widx = CW'($signed({2'b0, rcv}) - 1 - pos);
    smp = (32'(widx) < DEPTH) ? $signed(win[widx[IW-1:0]]) : 16'sd0;
    w = wt(tap_dist, weights_a, weights_b);
  end

  logic signed [32:0] prod;
  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, w}) * smp;
  end
  logic pvalid;
  logic [15:0] pw;
  logic mac_go;
  assign mac_go = cmd.mac_en && ({1'b0, step} < (JW+1)'(2 * k - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      rcv <= '0; emt <= '0; step <= '0; pvalid <= 1'b0; dbusy <= 1'b0;
    end else begin
      pvalid <= mac_go && present;
      if (cmd.shift_in) begin
        for (int i = DEPTH - 1; i > 0; i--) win[i] <= win[i-1];
        win[0] <= in_beat.sample_value;
        rcv <= rcv + CW'(1);
        last <= in_beat.sequence_end;
      end
      if (cmd.clear_acc) begin
        acc <= '0; wsum <= '0; step <= '0;
        centre <= $signed(win[IW'(rcv - CW'(1) - emt)]);
      end
      if (mac_go) begin
        step <= step + JW'(1);
        pw <= w;
      end
      if (pvalid) begin
        acc <= acc + AW'(prod);
        wsum <= wsum + WW'(pw);
      end
      if (cmd.div_start) begin
        rem <= '0;
        quo <= (AW+1)'({(acc[AW-1] ? -acc : acc), 1'b0}) + (AW+1)'(wsum);
        dcnt <= 7'd0;
        dbusy <= 1'b1;
      end else if (dbusy) begin
        logic [AW+1:0] t;
        t = {rem, quo[AW]};
        if (t >= (AW+2)'({wsum, 1'b0})) begin
          rem <= (AW+1)'(t - (AW+2)'({wsum, 1'b0}));
          quo <= {quo[AW-1:0], 1'b1};
        end else begin
          rem <= t[AW:0];
          quo <= {quo[AW-1:0], 1'b0};
        end
        dcnt <= dcnt + 7'd1;
        if (dcnt == 7'(AW)) dbusy <= 1'b0;
      end
      if (cmd.emit) begin
        emt <= emt + CW'(1);
        step <= '0;
      end
      if (cmd.drop) begin
        rcv <= rcv - CW'(1);
        emt <= emt - CW'(1);
      end
      if (cmd.clear_cnt) begin
        rcv <= '0; emt <= '0;
      end
    end
  end

  logic signed [16:0] r;
  always_comb begin
    if (wsum == '0) r = 17'(centre);
    else if (quo > (AW+1)'(32768)) r = acc[AW-1] ? -17'sd32768 : 17'sd32767;
    else if (acc[AW-1]) r = -$signed({1'b0, quo[15:0]}) ;
    else r = (quo[15:0] == 16'h8000) ? 17'sd32767 : $signed({1'b0, quo[15:0]});
    if (acc[AW-1] && quo == (AW+1)'(32768) && wsum != '0) r = -17'sd32768;
    result.smoothed_value = r[15:0];
    result.final_output = last && (emt + CW'(1) == rcv);
  end

  always_comb begin
    stat.mac_done = ({1'b0, step} >= (JW+1)'(2 * k - 1)) && !pvalid;
    stat.div_done = !dbusy && !cmd.div_start;
    stat.more = last ? (emt < rcv) : ((rcv - emt) >= k);
    stat.seq_last = last;
    stat.emt_over = (emt > CW'(MAX_TAPS));
  end
endmodule
`default_nettype wire

@@ hdl/sws_control.sv @@
// Controller state machine of the smoother; drives datapath commands and the
// channel handshakes. Depends on sws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sws_control import sws_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_fire,
  input  wire logic     out_fire,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          in_ready,
  output logic          out_valid
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_CHECK = 6'b000010, S_MAC = 6'b000100,
    S_DIV  = 6'b001000, S_OUT = 6'b010000, S_WAIT = 6'b100000
  } state_t;
  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.shift_in = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.more) begin
          cmd.clear_acc = 1'b1;
          state_next = S_MAC;
        end else begin
          if (stat.seq_last) cmd.clear_cnt = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        if (stat.mac_done) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: if (stat.div_done) state_next = S_OUT;
      S_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          cmd.emit = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!stat.seq_last && stat.emt_over) cmd.drop = 1'b1;
        state_next = S_CHECK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

@@ hdl/symmetric_weighted_smoother.sv @@
// Symmetric weighted smoother top level: config registers, controller, datapath;
// depends on sws_pkg, sws_control, sws_datapath.
// Per result the controller passes through its check, MAC, divide, out and wait states,
// holding in out while out_stall is high; an input beat is accepted in idle, then checked.
// Input is stalled until the results of an accepted beat are out; one beat at a time.
// Synchronous reset restores registers and counters; the sample window is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module symmetric_weighted_smoother import sws_pkg::*; #(
  parameter int MAX_TAPS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire in_beat_t    in_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  output out_beat_t        out_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  logic [3:0]  tap_count;
  logic [63:0] weights_a, weights_b;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic in_ready;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= 4'd1; weights_a <= 64'd32768; weights_b <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TAP_COUNT: tap_count <= cfg_data[3:0];
        REG_WEIGHTS_A: weights_a <= cfg_data;
        REG_WEIGHTS_B: weights_b <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !in_ready;

  sws_control u_ctl (
    .clk, .rst,
    .in_fire(in_valid && in_ready),
    .out_fire(out_valid && !out_stall),
    .stat, .cmd, .in_ready, .out_valid
  );

  sws_datapath #(.MAX_TAPS(MAX_TAPS)) u_dp (
    .clk, .rst, .in_beat(in_data), .tap_count, .weights_a, .weights_b,
    .cmd, .stat, .result(out_data)
  );
endmodule
`default_nettype wire

@@ hdl/sws_checker.sv @@
// Port checker for the smoother, bound to the top level. Depends on sws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sws_checker import sws_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_beat_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("hold");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("overlap");
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("one beat");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid) else $error("reset");
endmodule

bind symmetric_weighted_smoother sws_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire
